[rtl/slrg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slrg_pkg
// Shared types, constants and the Lehmer step function for the shuffled
// Lehmer random generator.
// ----------------------------------------------------------------------------
package slrg_pkg;

  localparam int unsigned WORD_W = 31;

  typedef logic [WORD_W-1:0] word_t;

  localparam logic [14:0]     LEHMER_MULT = 15'd16807;
  localparam logic [WORD_W:0] LEHMER_MOD  = 32'd2147483647;
  localparam word_t           SAT_LIMIT   = 31'd2147483389;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_DIV,
    ST_READ,
    ST_WRITE
  } state_t;

  // One step of state * 16807 mod (2^31 - 1), folded with the Mersenne trick.
  function automatic word_t lehmer_next(input word_t s);
    logic [WORD_W+14:0] prod;
    logic [WORD_W:0]    fold;
    logic [WORD_W:0]    red;
    prod = {15'b0, s} * {31'b0, LEHMER_MULT};
    fold = {1'b0, prod[WORD_W-1:0]} + {17'b0, prod[WORD_W+14:WORD_W]};
    red  = (fold >= LEHMER_MOD) ? (fold - LEHMER_MOD) : fold;
    return red[WORD_W-1:0];
  endfunction

endpackage

[rtl/slrg_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slrg_table
// Shuffle table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module slrg_table #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  slrg_pkg::word_t       wr_data,
  input  logic [AW-1:0]         rd_addr,
  output slrg_pkg::word_t       rd_data
);
  import slrg_pkg::*;

  word_t mem [DEPTH];
  word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/slrg_slot_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slrg_slot_div
// Slot index unit: divides the last output by the constant slot divisor with
// a reciprocal estimate and one correction step, then clamps to the table.
// ----------------------------------------------------------------------------
module slrg_slot_div #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  slrg_pkg::word_t       dividend,
  output logic                  done,
  output logic [AW-1:0]         slot
);
  import slrg_pkg::*;

  localparam int unsigned QW = $clog2(DEPTH + 1);
  localparam int unsigned PW = WORD_W + QW;
  // The estimate (x * floor(2^31 / NDIV)) >> 31 is never above the true
  // quotient and at most one below it, so one compare fixes it.
  localparam logic [63:0] NDIV64  = 64'd1 + 64'd2147483646 / 64'(DEPTH);
  localparam logic [63:0] RECIP64 = 64'h8000_0000 / NDIV64;
  localparam logic [PW-1:0] NDIV_P  = NDIV64[PW-1:0];
  localparam logic [PW-1:0] RECIP_P = RECIP64[PW-1:0];

  logic          load_r, load_nxt;
  logic          est_r, est_nxt;
  logic          done_r, done_nxt;
  word_t         x_r, x_nxt;
  logic [QW-1:0] qe_r, qe_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [PW-1:0] prod;
  logic [PW-1:0] back;
  logic [PW-1:0] rem;
  logic          fits;

  assign prod = PW'(x_r) * RECIP_P;
  assign back = PW'(qe_r) * NDIV_P;
  assign rem  = PW'(x_r) - back;
  assign fits = (rem >= NDIV_P);

  always_comb begin
    load_nxt = 1'b0;
    est_nxt  = 1'b0;
    done_nxt = 1'b0;
    x_nxt    = x_r;
    qe_nxt   = qe_r;
    q_nxt    = q_r;
    if (start) begin
      x_nxt    = dividend;
      load_nxt = 1'b1;
    end
    if (load_r) begin
      qe_nxt  = prod[PW-1:WORD_W];
      est_nxt = 1'b1;
    end
    if (est_r) begin
      q_nxt    = qe_r + QW'(fits);
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_r <= 1'b0;
      est_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      load_r <= load_nxt;
      est_r  <= est_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r  <= x_nxt;
    qe_r <= qe_nxt;
    q_r  <= q_nxt;
  end

  assign done = done_r;
  assign slot = (q_r >= QW'(DEPTH)) ? AW'(DEPTH - 1) : q_r[AW-1:0];

endmodule

[rtl/shuffled_lehmer_random_generator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shuffled_lehmer_random_generator_core
// Minimal standard Lehmer generator (x * 16807 mod 2^31-1) behind a
// Bays-Durham shuffle table; each request returns one saturated random word.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                              Direction
//   -------   --------------------------------   ----------------------------
//   in        in_valid/in_ready, in_reseed       request, into the core
//   out       out_valid/out_ready, out_value,    result word, out of the core
//             out_saturated
//   cfg       cfg_wr_en, cfg_wr_data             seed register write, no wait
//
// A normal request is accepted in idle; the next waits until its steps are
// done: the accept issues the table read, the write-back step writes back
// and registers the result, the slot index unit runs through its load,
// estimate and done registers, and then the new slot is loaded.
// A request that reinitializes first runs TABLE_DEPTH + 8 generator steps,
// one per cycle, the last TABLE_DEPTH written through the single write port
// of the table memory, then a slot computation and a table read. Reset is
// synchronous and active low; the table needs no clearing since the first
// request fills it. A result not taken holds the next request in write-back.
// ----------------------------------------------------------------------------
module shuffled_lehmer_random_generator_core #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_reseed,
  output logic                  out_valid,
  input  logic                  out_ready,
  output slrg_pkg::word_t       out_value,
  output logic                  out_saturated,
  input  logic                  cfg_wr_en,
  input  slrg_pkg::word_t       cfg_wr_data
);
  import slrg_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 8);

  state_t        state_r, state_nxt;
  word_t         seed_r, seed_nxt;
  word_t         gen_r, gen_nxt;
  logic          init_done_r, init_done_nxt;
  logic          pending_r, pending_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] slot_r, slot_nxt;
  logic          out_valid_r, out_valid_nxt;
  word_t         out_value_r, out_value_nxt;
  logic          out_sat_r, out_sat_nxt;

  word_t         gen_step;
  word_t         seed_start;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  word_t         mem_wdata;
  word_t         mem_rdata;
  logic          div_start;
  word_t         div_dividend;
  logic          div_done;
  logic [AW-1:0] div_slot;

  assign gen_step = lehmer_next(gen_r);

  // The seed 2^31-1 reduces to zero, and zero is taken as one.
  assign seed_start = (seed_r == '0 || seed_r == LEHMER_MOD[WORD_W-1:0]) ?
                      word_t'(1) : seed_r;

  slrg_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (slot_r),
    .rd_data (mem_rdata)
  );

  slrg_slot_div #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_slot_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .done     (div_done),
    .slot     (div_slot)
  );

  always_comb begin
    state_nxt     = state_r;
    seed_nxt      = cfg_wr_en ? cfg_wr_data : seed_r;
    gen_nxt       = gen_r;
    init_done_nxt = init_done_r;
    pending_nxt   = pending_r;
    cnt_nxt       = cnt_r;
    slot_nxt      = slot_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    out_sat_nxt   = out_sat_r;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r[AW-1:0];
    mem_wdata     = gen_step;
    div_start     = 1'b0;
    div_dividend  = gen_step;
    in_ready      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_reseed || !init_done_r) begin
            gen_nxt     = seed_start;
            cnt_nxt     = CW'(TABLE_DEPTH + 7);
            pending_nxt = 1'b1;
            state_nxt   = ST_INIT;
          end else begin
            // The table read of the current slot is issued this cycle.
            gen_nxt   = gen_step;
            state_nxt = ST_WRITE;
          end
        end
      end

      ST_INIT: begin
        // One generator step per cycle; the last TABLE_DEPTH steps fill
        // the table from the top slot down to slot zero.
        gen_nxt = gen_step;
        mem_we  = (cnt_r < CW'(TABLE_DEPTH));
        if (cnt_r == '0) begin
          init_done_nxt = 1'b1;
          div_start     = 1'b1;
          div_dividend  = gen_step;
          state_nxt     = ST_DIV;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end

      ST_DIV: begin
        if (div_done) begin
          slot_nxt  = div_slot;
          state_nxt = pending_r ? ST_READ : ST_IDLE;
        end
      end

      ST_READ: begin
        gen_nxt     = gen_step;
        pending_nxt = 1'b0;
        state_nxt   = ST_WRITE;
      end

      ST_WRITE: begin
        // Read data of the slot is valid here and stays valid while stalled.
        if (!out_valid_r || out_ready) begin
          mem_we        = 1'b1;
          mem_waddr     = slot_r;
          mem_wdata     = gen_r;
          out_valid_nxt = 1'b1;
          if (mem_rdata > SAT_LIMIT) begin
            out_value_nxt = SAT_LIMIT;
            out_sat_nxt   = 1'b1;
          end else begin
            out_value_nxt = mem_rdata;
            out_sat_nxt   = 1'b0;
          end
          div_start    = 1'b1;
          div_dividend = mem_rdata;
          state_nxt    = ST_DIV;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seed_r      <= word_t'(1);
      gen_r       <= word_t'(1);
      init_done_r <= 1'b0;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
      slot_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      seed_r      <= seed_nxt;
      gen_r       <= gen_nxt;
      init_done_r <= init_done_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
      slot_r      <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    out_value_r <= out_value_nxt;
    out_sat_r   <= out_sat_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_saturated = out_sat_r;

endmodule
